### rtl/core/plsf_pkg.sv
`timescale 1ns / 1ps

package plsf_pkg;

    localparam int OUT_W = 48;
    localparam int PC_W  = 5;
    localparam int CNT_OUT_W = 11;

    localparam logic [1:0] FIT_LIN = 2'd1;
    localparam logic [1:0] FIT_QUAD = 2'd2;

    localparam logic [OUT_W-1:0] OUT_MAX_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MAX_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_SOLVE,
        ST_LOAD,
        ST_MUL,
        ST_MAC,
        ST_CHECK,
        ST_DSET,
        ST_DIV,
        ST_DDONE,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        SRC_N,
        SRC_S1,
        SRC_S2,
        SRC_S3,
        SRC_S4,
        SRC_SY,
        SRC_SXY,
        SRC_SX2Y,
        SRC_C00,
        SRC_C01,
        SRC_C02,
        SRC_C11,
        SRC_C12,
        SRC_C22
    } t_src;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_C00,
        DST_C01,
        DST_C02,
        DST_C11,
        DST_C12,
        DST_C22,
        DST_DET,
        DST_DC,
        DST_DL,
        DST_DQ
    } t_dst;

    typedef struct packed {
        t_src a;
        t_src b;
        logic neg;
        logic first;
        t_dst dst;
        logic fin;
    } t_uop;

    function automatic t_uop mk(t_src a, t_src b, logic neg, logic first, t_dst dst,
                                logic fin);
        t_uop u;
        u.a = a;
        u.b = b;
        u.neg = neg;
        u.first = first;
        u.dst = dst;
        u.fin = fin;
        return u;
    endfunction

    // Each step adds +/- a*b to the running total; b is a sum or the count.
    function automatic t_uop uop_rom(logic lin, logic [PC_W-1:0] pc);
        t_uop u;
        u = mk(SRC_N, SRC_N, 1'b0, 1'b1, DST_NONE, 1'b1);
        if (lin) begin
            case (pc)
                5'd0: u = mk(SRC_N,  SRC_S2,  1'b0, 1'b1, DST_NONE, 1'b0);
                5'd1: u = mk(SRC_S1, SRC_S1,  1'b1, 1'b0, DST_DET,  1'b0);
                5'd2: u = mk(SRC_SY, SRC_S2,  1'b0, 1'b1, DST_NONE, 1'b0);
                5'd3: u = mk(SRC_S1, SRC_SXY, 1'b1, 1'b0, DST_DC,   1'b0);
                5'd4: u = mk(SRC_N,  SRC_SXY, 1'b0, 1'b1, DST_NONE, 1'b0);
                5'd5: u = mk(SRC_S1, SRC_SY,  1'b1, 1'b0, DST_DL,   1'b1);
                default: u = mk(SRC_N, SRC_N, 1'b0, 1'b1, DST_NONE, 1'b1);
            endcase
        end else begin
            case (pc)
                5'd0:  u = mk(SRC_S2,  SRC_S4,   1'b0, 1'b1, DST_NONE, 1'b0);
                5'd1:  u = mk(SRC_S3,  SRC_S3,   1'b1, 1'b0, DST_C00,  1'b0);
                5'd2:  u = mk(SRC_S2,  SRC_S3,   1'b0, 1'b1, DST_NONE, 1'b0);
                5'd3:  u = mk(SRC_S1,  SRC_S4,   1'b1, 1'b0, DST_C01,  1'b0);
                5'd4:  u = mk(SRC_S1,  SRC_S3,   1'b0, 1'b1, DST_NONE, 1'b0);
                5'd5:  u = mk(SRC_S2,  SRC_S2,   1'b1, 1'b0, DST_C02,  1'b0);
                5'd6:  u = mk(SRC_N,   SRC_S4,   1'b0, 1'b1, DST_NONE, 1'b0);
                5'd7:  u = mk(SRC_S2,  SRC_S2,   1'b1, 1'b0, DST_C11,  1'b0);
                5'd8:  u = mk(SRC_S1,  SRC_S2,   1'b0, 1'b1, DST_NONE, 1'b0);
                5'd9:  u = mk(SRC_N,   SRC_S3,   1'b1, 1'b0, DST_C12,  1'b0);
                5'd10: u = mk(SRC_N,   SRC_S2,   1'b0, 1'b1, DST_NONE, 1'b0);
                5'd11: u = mk(SRC_S1,  SRC_S1,   1'b1, 1'b0, DST_C22,  1'b0);
                5'd12: u = mk(SRC_C00, SRC_N,    1'b0, 1'b1, DST_NONE, 1'b0);
                5'd13: u = mk(SRC_C01, SRC_S1,   1'b0, 1'b0, DST_NONE, 1'b0);
                5'd14: u = mk(SRC_C02, SRC_S2,   1'b0, 1'b0, DST_DET,  1'b0);
                5'd15: u = mk(SRC_C00, SRC_SY,   1'b0, 1'b1, DST_NONE, 1'b0);
                5'd16: u = mk(SRC_C01, SRC_SXY,  1'b0, 1'b0, DST_NONE, 1'b0);
                5'd17: u = mk(SRC_C02, SRC_SX2Y, 1'b0, 1'b0, DST_DC,   1'b0);
                5'd18: u = mk(SRC_C01, SRC_SY,   1'b0, 1'b1, DST_NONE, 1'b0);
                5'd19: u = mk(SRC_C11, SRC_SXY,  1'b0, 1'b0, DST_NONE, 1'b0);
                5'd20: u = mk(SRC_C12, SRC_SX2Y, 1'b0, 1'b0, DST_DL,   1'b0);
                5'd21: u = mk(SRC_C02, SRC_SY,   1'b0, 1'b1, DST_NONE, 1'b0);
                5'd22: u = mk(SRC_C12, SRC_SXY,  1'b0, 1'b0, DST_NONE, 1'b0);
                5'd23: u = mk(SRC_C22, SRC_SX2Y, 1'b0, 1'b0, DST_DQ,   1'b1);
                default: u = mk(SRC_N, SRC_N, 1'b0, 1'b1, DST_NONE, 1'b1);
            endcase
        end
        return u;
    endfunction

endpackage

### rtl/core/polynomial_least_squares_fit.sv
`timescale 1ns / 1ps

// Least-squares polynomial fit of first or second order over a set of points.
// Input channel: an item (x, y, last) is taken at a rising edge with start high
// and busy low. Each point within MAX_POINTS is folded into the running sums by one
// shared multiplier while busy stays high, so no new point is taken until it is done.
// On an item with last set the normal equations are solved by Cramer's rule
// with one shift-and-add multiplier and one restoring divider, both bit-serial.
// The solve runs 24 micro-steps for a quadratic fit and 6 for a linear one,
// each a bit-serial product added to a running total, then, unless the
// determinant is zero, one restoring division per coefficient.
// The result item is then shown for exactly one cycle with o_result_valid high;
// the receiver cannot stall, so it must take it in that cycle. The sums, the
// count and the drop flag are then cleared and busy falls.
// The configuration channel writes fit_order (1 linear, anything else quadratic)
// and is ready only while the block is idle.
// Reset (synchronous, active low) clears all sums, the count and the drop flag and sets fit_order
// to quadratic.
module polynomial_least_squares_fit #(
    parameter int MAX_POINTS = 1024,
    parameter int X_BITS     = 12,
    parameter int Y_BITS     = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [X_BITS-1:0]          i_x,
    input  logic signed [Y_BITS-1:0]          i_y,
    input  logic                              i_last,
    output logic                              o_result_valid,
    output logic signed [plsf_pkg::OUT_W-1:0] o_coef_quad,
    output logic signed [plsf_pkg::OUT_W-1:0] o_coef_lin,
    output logic signed [plsf_pkg::OUT_W-1:0] o_coef_const,
    output logic                              o_singular,
    output logic                              o_dropped,
    output logic [plsf_pkg::CNT_OUT_W-1:0]    o_point_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_data
);

    // Count width, then one common width for every sum, sized for the largest.
    localparam int CB  = $clog2(MAX_POINTS + 1);
    localparam int PW  = (4 * X_BITS > 2 * X_BITS + Y_BITS) ? 4 * X_BITS
                                                            : 2 * X_BITS + Y_BITS;
    localparam int SW  = PW + CB + 1;
    // Cofactors, determinants and numerators all fit this signed width.
    localparam int DW  = 3 * SW + 2;
    // Dividend: |num| shifted up by FRAC_BITS+1 plus the rounding term.
    localparam int NW  = DW + FRAC_BITS + 2;
    localparam int CW  = $clog2(NW + 1);
    // Shared multiplier of the accumulation phase.
    localparam int AW  = 3 * X_BITS;
    localparam int BW  = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
    localparam int OW  = plsf_pkg::OUT_W;

    plsf_pkg::t_state r_state, n_state;

    logic [1:0]                r_order;
    logic [CB-1:0]             r_total;
    logic                      r_ovf;
    logic signed [SW-1:0]      r_s1, r_s2, r_s3, r_s4, r_sy, r_sxy, r_sx2y;

    logic signed [X_BITS-1:0]  r_x;
    logic signed [Y_BITS-1:0]  r_y;
    logic                      r_last;
    logic signed [2*X_BITS-1:0] r_x2;
    logic signed [AW-1:0]      r_x3;
    logic [CW-1:0]             r_cnt;

    logic [plsf_pkg::PC_W-1:0] r_pc;
    logic signed [DW-1:0]      r_c00, r_c01, r_c02, r_c11, r_c12, r_c22;
    logic signed [DW-1:0]      r_det, r_dc, r_dl, r_dq, r_acc;
    logic [DW-1:0]             r_ma, r_prod;
    logic [SW-1:0]             r_mb;
    logic                      r_mneg;

    logic [1:0]                r_dk;
    logic [NW-1:0]             r_dn, r_q;
    logic [DW:0]               r_dd, r_rem;
    logic                      r_dneg;

    logic signed [OW-1:0]      r_cq, r_cl, r_cc;
    logic                      r_sing;

    logic                      w_accept, w_lin, w_room;
    plsf_pkg::t_uop            w_uop;
    logic signed [DW-1:0]      w_a_val;
    logic signed [SW-1:0]      w_b_val;
    logic [DW-1:0]             w_a_abs;
    logic [SW-1:0]             w_b_abs;
    logic signed [DW-1:0]      w_term, w_acc_new;
    logic signed [AW-1:0]      w_ma;
    logic signed [BW-1:0]      w_mb;
    logic signed [AW+BW-1:0]   w_mprod;
    logic signed [DW-1:0]      w_num;
    logic [DW-1:0]             w_num_abs, w_det_abs;
    logic [DW+1:0]             w_rem_sh, w_diff;
    logic                      w_ge;
    logic [OW-1:0]             w_lim, w_mag, w_coef;

    assign w_accept = start && !busy;
    assign w_lin    = (r_order == plsf_pkg::FIT_LIN);
    assign w_room   = (r_total < CB'(MAX_POINTS));
    assign w_uop    = plsf_pkg::uop_rom(w_lin, r_pc);

    // Operand selection for the solve multiplier.
    always_comb begin
        case (w_uop.a)
            plsf_pkg::SRC_N:    w_a_val = DW'(r_total);
            plsf_pkg::SRC_S1:   w_a_val = DW'(r_s1);
            plsf_pkg::SRC_S2:   w_a_val = DW'(r_s2);
            plsf_pkg::SRC_S3:   w_a_val = DW'(r_s3);
            plsf_pkg::SRC_S4:   w_a_val = DW'(r_s4);
            plsf_pkg::SRC_SY:   w_a_val = DW'(r_sy);
            plsf_pkg::SRC_SXY:  w_a_val = DW'(r_sxy);
            plsf_pkg::SRC_SX2Y: w_a_val = DW'(r_sx2y);
            plsf_pkg::SRC_C00:  w_a_val = r_c00;
            plsf_pkg::SRC_C01:  w_a_val = r_c01;
            plsf_pkg::SRC_C02:  w_a_val = r_c02;
            plsf_pkg::SRC_C11:  w_a_val = r_c11;
            plsf_pkg::SRC_C12:  w_a_val = r_c12;
            plsf_pkg::SRC_C22:  w_a_val = r_c22;
            default:            w_a_val = '0;
        endcase
        case (w_uop.b)
            plsf_pkg::SRC_N:    w_b_val = SW'(r_total);
            plsf_pkg::SRC_S1:   w_b_val = r_s1;
            plsf_pkg::SRC_S2:   w_b_val = r_s2;
            plsf_pkg::SRC_S3:   w_b_val = r_s3;
            plsf_pkg::SRC_S4:   w_b_val = r_s4;
            plsf_pkg::SRC_SY:   w_b_val = r_sy;
            plsf_pkg::SRC_SXY:  w_b_val = r_sxy;
            plsf_pkg::SRC_SX2Y: w_b_val = r_sx2y;
            default:            w_b_val = '0;
        endcase
    end

    assign w_a_abs   = w_a_val[DW-1] ? DW'(-w_a_val) : DW'(w_a_val);
    assign w_b_abs   = w_b_val[SW-1] ? SW'(-w_b_val) : SW'(w_b_val);
    assign w_term    = r_mneg ? -$signed(r_prod) : $signed(r_prod);
    assign w_acc_new = (w_uop.first ? DW'(0) : r_acc) + w_term;

    // Shared multiplier of the per-point phase, one product a cycle.
    always_comb begin
        case (r_cnt[2:0])
            3'd0:    begin w_ma = AW'(r_x);  w_mb = BW'(r_x); end
            3'd1:    begin w_ma = AW'(r_x2); w_mb = BW'(r_x); end
            3'd2:    begin w_ma = r_x3;      w_mb = BW'(r_x); end
            3'd3:    begin w_ma = AW'(r_x);  w_mb = BW'(r_y); end
            3'd4:    begin w_ma = AW'(r_x2); w_mb = BW'(r_y); end
            default: begin w_ma = '0;        w_mb = '0;       end
        endcase
    end
    assign w_mprod = w_ma * w_mb;

    // Divider operands and the restoring step.
    always_comb begin
        case (r_dk)
            2'd0:    w_num = r_dq;
            2'd1:    w_num = r_dl;
            default: w_num = r_dc;
        endcase
    end
    assign w_num_abs = w_num[DW-1] ? DW'(-w_num) : DW'(w_num);
    assign w_det_abs = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
    assign w_rem_sh  = {r_rem, r_dn[NW-1]};
    assign w_diff    = w_rem_sh - {1'b0, r_dd};
    assign w_ge      = !w_diff[DW+1];
    assign w_lim     = r_dneg ? plsf_pkg::OUT_MAX_NEG : plsf_pkg::OUT_MAX_POS;
    assign w_mag     = (r_q < NW'(w_lim)) ? r_q[OW-1:0] : w_lim;
    assign w_coef    = r_dneg ? OW'(-w_mag) : w_mag;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            plsf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_room) begin
                        n_state = plsf_pkg::ST_ACC;
                    end else if (i_last) begin
                        n_state = plsf_pkg::ST_SOLVE;
                    end
                end
            end
            plsf_pkg::ST_ACC: begin
                if (r_cnt == CW'(4)) begin
                    n_state = r_last ? plsf_pkg::ST_SOLVE : plsf_pkg::ST_IDLE;
                end
            end
            plsf_pkg::ST_SOLVE: n_state = plsf_pkg::ST_LOAD;
            plsf_pkg::ST_LOAD:  n_state = plsf_pkg::ST_MUL;
            plsf_pkg::ST_MUL: begin
                if (r_cnt == CW'(SW - 1)) begin
                    n_state = plsf_pkg::ST_MAC;
                end
            end
            plsf_pkg::ST_MAC: begin
                n_state = w_uop.fin ? plsf_pkg::ST_CHECK : plsf_pkg::ST_LOAD;
            end
            plsf_pkg::ST_CHECK: begin
                n_state = (r_det == '0) ? plsf_pkg::ST_OUT : plsf_pkg::ST_DSET;
            end
            plsf_pkg::ST_DSET: n_state = plsf_pkg::ST_DIV;
            plsf_pkg::ST_DIV: begin
                if (r_cnt == CW'(NW - 1)) begin
                    n_state = plsf_pkg::ST_DDONE;
                end
            end
            plsf_pkg::ST_DDONE: begin
                n_state = (r_dk == 2'd2) ? plsf_pkg::ST_OUT : plsf_pkg::ST_DSET;
            end
            plsf_pkg::ST_OUT: n_state = plsf_pkg::ST_IDLE;
            default:          n_state = plsf_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        busy           = (r_state != plsf_pkg::ST_IDLE);
        o_cfg_ready    = (r_state == plsf_pkg::ST_IDLE);
        o_result_valid = (r_state == plsf_pkg::ST_OUT);
    end

    assign o_coef_quad   = r_cq;
    assign o_coef_lin    = r_cl;
    assign o_coef_const  = r_cc;
    assign o_singular    = r_sing;
    assign o_dropped     = r_ovf;
    assign o_point_count = plsf_pkg::CNT_OUT_W'(r_total);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plsf_pkg::ST_IDLE;
            r_order <= plsf_pkg::FIT_QUAD;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_s1    <= '0;
            r_s2    <= '0;
            r_s3    <= '0;
            r_s4    <= '0;
            r_sy    <= '0;
            r_sxy   <= '0;
            r_sx2y  <= '0;
            r_cnt   <= '0;
            r_pc    <= '0;
            r_dk    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_order <= i_cfg_data;
            end
            case (r_state)
                plsf_pkg::ST_IDLE: begin
                    r_cnt <= '0;
                    if (w_accept && !w_room) begin
                        r_ovf <= 1'b1;
                    end
                end
                plsf_pkg::ST_ACC: begin
                    r_cnt <= r_cnt + 1'b1;
                    case (r_cnt[2:0])
                        3'd0: begin
                            r_total <= r_total + 1'b1;
                            r_s1    <= r_s1 + SW'(r_x);
                            r_sy    <= r_sy + SW'(r_y);
                        end
                        3'd1: r_s2   <= r_s2 + SW'(r_x2);
                        3'd2: begin
                            r_s3 <= r_s3 + SW'(r_x3);
                            r_s4 <= r_s4 + SW'(w_mprod);
                        end
                        3'd3: r_sxy  <= r_sxy + SW'(w_mprod);
                        3'd4: r_sx2y <= r_sx2y + SW'(w_mprod);
                        default: ;
                    endcase
                end
                plsf_pkg::ST_SOLVE: r_pc <= '0;
                plsf_pkg::ST_LOAD:  r_cnt <= '0;
                plsf_pkg::ST_MUL:   r_cnt <= r_cnt + 1'b1;
                plsf_pkg::ST_MAC:   r_pc <= r_pc + 1'b1;
                plsf_pkg::ST_CHECK: r_dk <= '0;
                plsf_pkg::ST_DSET:  r_cnt <= '0;
                plsf_pkg::ST_DIV:   r_cnt <= r_cnt + 1'b1;
                plsf_pkg::ST_DDONE: r_dk <= r_dk + 1'b1;
                plsf_pkg::ST_OUT: begin
                    // The set is finished: start the next one from empty.
                    r_total <= '0;
                    r_ovf   <= 1'b0;
                    r_s1    <= '0;
                    r_s2    <= '0;
                    r_s3    <= '0;
                    r_s4    <= '0;
                    r_sy    <= '0;
                    r_sxy   <= '0;
                    r_sx2y  <= '0;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            plsf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_x    <= i_x;
                    r_y    <= i_y;
                    r_last <= i_last;
                end
            end
            plsf_pkg::ST_ACC: begin
                if (r_cnt[2:0] == 3'd0) begin
                    r_x2 <= (2 * X_BITS)'(w_mprod);
                end
                if (r_cnt[2:0] == 3'd1) begin
                    r_x3 <= AW'(w_mprod);
                end
            end
            plsf_pkg::ST_SOLVE: begin
                r_dq <= '0;
            end
            plsf_pkg::ST_LOAD: begin
                r_ma   <= w_a_abs;
                r_mb   <= w_b_abs;
                r_mneg <= w_a_val[DW-1] ^ w_b_val[SW-1] ^ w_uop.neg;
                r_prod <= '0;
            end
            plsf_pkg::ST_MUL: begin
                r_prod <= r_prod + (r_mb[0] ? r_ma : DW'(0));
                r_ma   <= r_ma << 1;
                r_mb   <= r_mb >> 1;
            end
            plsf_pkg::ST_MAC: begin
                r_acc <= w_acc_new;
                case (w_uop.dst)
                    plsf_pkg::DST_C00: r_c00 <= w_acc_new;
                    plsf_pkg::DST_C01: r_c01 <= w_acc_new;
                    plsf_pkg::DST_C02: r_c02 <= w_acc_new;
                    plsf_pkg::DST_C11: r_c11 <= w_acc_new;
                    plsf_pkg::DST_C12: r_c12 <= w_acc_new;
                    plsf_pkg::DST_C22: r_c22 <= w_acc_new;
                    plsf_pkg::DST_DET: r_det <= w_acc_new;
                    plsf_pkg::DST_DC:  r_dc  <= w_acc_new;
                    plsf_pkg::DST_DL:  r_dl  <= w_acc_new;
                    plsf_pkg::DST_DQ:  r_dq  <= w_acc_new;
                    default: ;
                endcase
            end
            plsf_pkg::ST_CHECK: begin
                // A zero determinant gives the singular result with zero terms.
                r_sing <= (r_det == '0);
                r_cq   <= '0;
                r_cl   <= '0;
                r_cc   <= '0;
            end
            plsf_pkg::ST_DSET: begin
                // Round to nearest, ties away from zero: (2|n|2^F + |d|) / 2|d|.
                r_dneg <= w_num[DW-1] ^ r_det[DW-1];
                r_dn   <= (NW'(w_num_abs) << (FRAC_BITS + 1)) + NW'(w_det_abs);
                r_dd   <= {w_det_abs, 1'b0};
                r_rem  <= '0;
                r_q    <= '0;
            end
            plsf_pkg::ST_DIV: begin
                r_rem <= w_ge ? w_diff[DW:0] : w_rem_sh[DW:0];
                r_dn  <= r_dn << 1;
                r_q   <= {r_q[NW-2:0], w_ge};
            end
            plsf_pkg::ST_DDONE: begin
                case (r_dk)
                    2'd0:    r_cq <= w_coef;
                    2'd1:    r_cl <= w_coef;
                    default: r_cc <= w_coef;
                endcase
            end
            default: ;
        endcase
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int       MAX_PTS     = 1024;
    localparam int       FRAC        = 16;
    localparam longint   CYCLE_LIMIT = 10000000;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        logic [plsf_pkg::OUT_W-1:0]     quad;
        logic [plsf_pkg::OUT_W-1:0]     lin;
        logic [plsf_pkg::OUT_W-1:0]     cnst;
        logic                           singular;
        logic                           dropped;
        logic [plsf_pkg::CNT_OUT_W-1:0] count;
    } t_fit;

    // Keeps its own copy of the sums and of fit_order, and the queue of fits
    // still owed by the block.
    class fit_predictor;
        logic [1:0] order;
        int         total;
        bit         overflow;
        longint     sx, sx2, sx3, sx4, sy, sxy, sx2y;
        t_fit       expected_fits[$];
        int         mismatches;
        int         fits_checked;

        function new();
            order = plsf_pkg::FIT_QUAD;
            mismatches = 0;
            fits_checked = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            total = 0;
            overflow = 0;
            sx = 0; sx2 = 0; sx3 = 0; sx4 = 0; sy = 0; sxy = 0; sx2y = 0;
        endfunction

        function void set_order(logic [1:0] v);
            order = v;
        endfunction

        function t_wide det3(t_wide a, t_wide b, t_wide c, t_wide d, t_wide e,
                             t_wide f, t_wide g, t_wide h, t_wide k);
            return a * (e * k - f * h) - b * (d * k - f * g) + c * (d * h - e * g);
        endfunction

        // Rounds num * 2^FRAC / den to nearest, ties away from zero, then
        // saturates to the 48-bit output range.
        function logic [plsf_pkg::OUT_W-1:0] ratio(t_wide num, t_wide den);
            bit    neg;
            t_wide n, d, q, lim;
            neg = (num < 0) != (den < 0);
            n = (num < 0) ? -num : num;
            d = (den < 0) ? -den : den;
            n = n <<< FRAC;
            q = (2 * n + d) / (2 * d);
            lim = neg ? (t_wide'(1) <<< 47) : ((t_wide'(1) <<< 47) - 1);
            if (q >= lim) q = lim;
            return neg ? -q[plsf_pkg::OUT_W-1:0] : q[plsf_pkg::OUT_W-1:0];
        endfunction

        function void note_point(logic signed [11:0] x, logic signed [15:0] y,
                                 logic last);
            longint xv, yv;
            t_wide  n, s1, s2, s3, s4, ty, txy, tx2y, det, dq, dl, dc;
            t_fit   f;
            xv = x;
            yv = y;
            if (total < MAX_PTS) begin
                total++;
                sx += xv;
                sx2 += xv * xv;
                sx3 += xv * xv * xv;
                sx4 += xv * xv * xv * xv;
                sy += yv;
                sxy += xv * yv;
                sx2y += xv * xv * yv;
            end else begin
                overflow = 1;
            end
            if (!last) return;
            n = total; s1 = sx; s2 = sx2; s3 = sx3; s4 = sx4;
            ty = sy; txy = sxy; tx2y = sx2y;
            if (order == plsf_pkg::FIT_LIN) begin
                det = n * s2 - s1 * s1;
                dc = ty * s2 - s1 * txy;
                dl = n * txy - s1 * ty;
                dq = 0;
            end else begin
                det = det3(n, s1, s2, s1, s2, s3, s2, s3, s4);
                dc = det3(ty, s1, s2, txy, s2, s3, tx2y, s3, s4);
                dl = det3(n, ty, s2, s1, txy, s3, s2, tx2y, s4);
                dq = det3(n, s1, ty, s1, s2, txy, s2, s3, tx2y);
            end
            if (det == 0) begin
                f.quad = '0; f.lin = '0; f.cnst = '0; f.singular = 1'b1;
            end else begin
                f.quad = ratio(dq, det);
                f.lin = ratio(dl, det);
                f.cnst = ratio(dc, det);
                f.singular = 1'b0;
            end
            f.dropped = overflow;
            f.count = total[plsf_pkg::CNT_OUT_W-1:0];
            expected_fits.push_back(f);
            clear_sums();
        endfunction

        function void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on fit %0d, %s: expected %0h, got %0h",
                         fits_checked, what, exp_v, act_v);
        endfunction

        function void check_fit(t_fit got);
            t_fit e;
            if (expected_fits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result item with no fit outstanding");
                return;
            end
            e = expected_fits.pop_front();
            if (got.quad !== e.quad) report("coef_quad", e.quad, got.quad);
            if (got.lin !== e.lin) report("coef_lin", e.lin, got.lin);
            if (got.cnst !== e.cnst) report("coef_const", e.cnst, got.cnst);
            if (got.singular !== e.singular) report("singular", e.singular, got.singular);
            if (got.dropped !== e.dropped) report("dropped", e.dropped, got.dropped);
            if (got.count !== e.count) report("point_count", e.count, got.count);
            fits_checked++;
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [11:0]   i_x;
    logic signed [15:0]   i_y;
    logic                 i_last;
    logic                 o_result_valid;
    logic signed [plsf_pkg::OUT_W-1:0] o_coef_quad, o_coef_lin, o_coef_const;
    logic                 o_singular, o_dropped;
    logic [plsf_pkg::CNT_OUT_W-1:0] o_point_count;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [1:0]           i_cfg_data;

    fit_predictor model;
    int     burst_left;
    int     points_sent;
    int     order_writes;
    longint cycle_count = 0;

    polynomial_least_squares_fit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_x            (i_x),
        .i_y            (i_y),
        .i_last         (i_last),
        .o_result_valid (o_result_valid),
        .o_coef_quad    (o_coef_quad),
        .o_coef_lin     (o_coef_lin),
        .o_coef_const   (o_coef_const),
        .o_singular     (o_singular),
        .o_dropped      (o_dropped),
        .o_point_count  (o_point_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The receiver cannot push back, so every strobed cycle is one result item.
    always @(posedge i_clk) begin
        t_fit got;
        if (i_rst_n && o_result_valid) begin
            got.quad = o_coef_quad;
            got.lin = o_coef_lin;
            got.cnst = o_coef_const;
            got.singular = o_singular;
            got.dropped = o_dropped;
            got.count = o_point_count;
            model.check_fit(got);
        end
    end

    // Watchdog: a hung block must not leave the run spinning forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** polynomial_least_squares_fit: FAILED **");
            $finish;
        end
    end

    // Presents one point and holds it until the block takes it. The sender
    // works in bursts; between bursts start is dropped for a random gap, which may be empty.
    task automatic send_point(logic signed [11:0] x, logic signed [15:0] y, logic last);
        if (burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15))
                @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        start = 1'b1;
        i_x = x;
        i_y = y;
        i_last = last;
        do @(posedge i_clk); while (busy);
        model.note_point(x, y, last);
        points_sent++;
        @(negedge i_clk);
    endtask

    // fit_order is only written once the block has returned every fit and
    // had time to finish folding in any trailing point.
    task automatic write_order(logic [1:0] v);
        start = 1'b0;
        while (model.expected_fits.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        model.set_order(v);
        order_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data = 2'($urandom_range(0, 3));
    endtask

    // One set of points. Flavours: full-range x, a narrow band of x, and all
    // points on one abscissa so that the system is singular.
    task automatic send_set(int count, int flavour);
        logic signed [11:0] x;
        logic signed [15:0] y;
        logic signed [11:0] fixed_x;
        fixed_x = 12'($urandom);
        for (int i = 0; i < count; i++) begin
            case (flavour)
                0: x = 12'($urandom);
                1: x = $signed(12'($urandom_range(0, 16))) - 12'sd8;
                default: x = fixed_x;
            endcase
            y = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 64)) - 16'sd32
                                            : 16'($urandom);
            send_point(x, y, i == count - 1);
        end
    endtask

    initial begin
        logic [1:0] order_plan[6];
        int         set_len;
        model = new();
        burst_left = 0;
        points_sent = 0;
        order_writes = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_x = '0;
        i_y = '0;
        i_last = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes under the reset order (quadratic), a lone point, two points and
        // three on one x (all singular), then linear sets, then quadratic ones under orders 0 and 3.
        send_point(-12'sd2048, -16'sd32768, 1'b0);
        send_point(12'sd2047, 16'sd32767, 1'b0);
        send_point(12'sd0, -16'sd1, 1'b0);
        send_point(-12'sd1, 16'sd0, 1'b1);
        send_point(12'sd5, 16'sd7, 1'b1);
        send_point(12'sd1, 16'sd3, 1'b0);
        send_point(12'sd2, 16'sd9, 1'b1);
        send_point(12'sd3, 16'sd1, 1'b0);
        send_point(12'sd3, 16'sd2, 1'b0);
        send_point(12'sd3, 16'sd4, 1'b1);
        write_order(plsf_pkg::FIT_LIN);
        send_point(-12'sd2048, 16'sd32767, 1'b0);
        send_point(12'sd2047, -16'sd32768, 1'b1);
        send_point(12'sd0, -16'sd32768, 1'b0);
        send_point(12'sd1, 16'sd32767, 1'b1);
        send_point(12'sd9, 16'sd9, 1'b1);
        send_point(12'sd4, 16'sd1, 1'b0);
        send_point(12'sd4, 16'sd8, 1'b1);
        write_order(2'd0);
        send_point(12'sd0, 16'sd0, 1'b0);
        send_point(12'sd1, 16'sd1, 1'b0);
        send_point(12'sd2, 16'sd4, 1'b1);
        write_order(2'd3);
        send_point(-12'sd1, 16'sd1, 1'b0);
        send_point(12'sd0, 16'sd0, 1'b0);
        send_point(12'sd1, 16'sd1, 1'b1);

        // Random sets under a rotating fit order, mostly short ones.
        order_plan = '{plsf_pkg::FIT_LIN, 2'd3, plsf_pkg::FIT_QUAD, 2'd0,
                       plsf_pkg::FIT_LIN, plsf_pkg::FIT_QUAD};
        for (int phase = 0; phase < 6; phase++) begin
            write_order(order_plan[phase]);
            while (points_sent < 25 + (phase + 1) * 113) begin
                case ($urandom_range(0, 9))
                    0: set_len = $urandom_range(1, 2);
                    1: set_len = $urandom_range(20, 40);
                    default: set_len = $urandom_range(3, 10);
                endcase
                case ($urandom_range(0, 9))
                    0: send_set(set_len, 2);
                    1, 2, 3: send_set(set_len, 1);
                    default: send_set(set_len, 0);
                endcase
            end
        end
        start = 1'b0;

        while (model.expected_fits.size() != 0) @(posedge i_clk);
        repeat (2500) @(posedge i_clk);

        $display("sent %0d points, checked %0d fits across %0d fit_order writes",
                 points_sent, model.fits_checked, order_writes);
        $display("mismatches: %0d, fits still outstanding: %0d",
                 model.mismatches, model.expected_fits.size());
        if (model.mismatches == 0 && model.expected_fits.size() == 0) begin
            $display("** polynomial_least_squares_fit: PASSED **");
        end else begin
            $display("** polynomial_least_squares_fit: FAILED **");
        end
        $finish;
    end

endmodule

### polynomial_least_squares_fit.f
rtl/core/plsf_pkg.sv
rtl/core/polynomial_least_squares_fit.sv
sim/tb.sv
